/* rtl/core/aapr_pkg.sv */
// Shared constants, microcode types and the sequencer program of the acceleration autopilot.
package aapr_pkg;

  // Fixed-point formats
  localparam int STATE_WIDTH     = 48;
  localparam int STATE_FRAC_BITS = 24;
  localparam int VAL_W           = 64;

  // Working store and sequencer sizing
  localparam int ADDR_W    = 6;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CH_LEN    = 29;
  localparam int TAIL_LEN  = 4;
  localparam int PROG_LEN  = 2 * CH_LEN + TAIL_LEN;
  localparam int PC_W      = $clog2(PROG_LEN);
  localparam int MUL_STEPS = VAL_W;
  localparam int DIV_STEPS = 2 * VAL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] STATE_MAX = (64'd1 << (STATE_WIDTH - 1)) - 64'd1;
  localparam logic [VAL_W-1:0] RAD2DEG   = 64'd61520874802;  // 180/pi, 30 fraction bits

  // Configuration register indexes
  localparam logic [2:0] CFG_GRAVITY   = 3'd0;
  localparam logic [2:0] CFG_REF_AREA  = 3'd1;
  localparam logic [2:0] CFG_MAX_INC   = 3'd2;
  localparam logic [2:0] CFG_GAIN_RAT  = 3'd3;
  localparam logic [2:0] CFG_RATE_TC   = 3'd4;
  localparam logic [2:0] CFG_LOOP_GAIN = 3'd5;
  localparam logic [2:0] CFG_TIME_STEP = 3'd6;

  // Temporary slots (per channel)
  localparam logic [3:0] T_QA    = 4'd0;
  localparam logic [3:0] T_T0    = 4'd1;
  localparam logic [3:0] T_DEN   = 4'd2;
  localparam logic [3:0] T_NUM   = 4'd3;
  localparam logic [3:0] T_TI    = 4'd4;
  localparam logic [3:0] T_FORCE = 4'd5;
  localparam logic [3:0] T_ACC   = 4'd6;
  localparam logic [3:0] T_ERR   = 4'd7;
  localparam logic [3:0] T_GR    = 4'd8;
  localparam logic [3:0] T_GI    = 4'd9;
  localparam logic [3:0] T_RC    = 4'd10;
  localparam logic [3:0] T_T1    = 4'd11;

  // State slots (per channel, per bank)
  localparam logic [3:0] ST_INT   = 4'd0;
  localparam logic [3:0] ST_INTD  = 4'd1;
  localparam logic [3:0] ST_RATE  = 4'd2;
  localparam logic [3:0] ST_RATED = 4'd3;
  localparam logic [3:0] ST_ANG   = 4'd4;
  localparam logic [3:0] ST_ANGD  = 4'd5;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_COMMIT
  } op_e;

  typedef enum logic [4:0] {
    SRC_TMP, SRC_OLD, SRC_NEW, SRC_DYNP, SRC_AREA, SRC_THR, SRC_SPEED, SRC_MASS,
    SRC_ASLOPE, SRC_COEF, SRC_CMD, SRC_GRAV, SRC_GACP, SRC_TR, SRC_TA, SRC_DT,
    SRC_RAD, SRC_ONE
  } src_e;

  typedef enum logic [2:0] {
    DST_TMP, DST_NEW, DST_ALPHA, DST_BETA, DST_LAG
  } dst_e;

  typedef struct packed {
    op_e               op;
    src_e              a_src;
    logic [3:0]        a_idx;
    src_e              b_src;
    logic [3:0]        b_idx;
    logic signed [6:0] shift;      // scale of product, or numerator pre-shift for divide
    dst_e              dst;
    logic [3:0]        d_idx;
    logic              neg;        // negate the saturated sum
    logic              sat_state;  // clamp to the state range
    logic              chk_zero;   // flag a fault on a zero result
    logic              ch;         // 0 pitch, 1 yaw
    logic              last;
  } uinst_t;

  function automatic uinst_t mk(op_e op, src_e as, logic [3:0] ai, src_e bs,
                                logic [3:0] bi, int sh, dst_e d, logic [3:0] di);
    uinst_t u;
    u.op        = op;
    u.a_src     = as;
    u.a_idx     = ai;
    u.b_src     = bs;
    u.b_idx     = bi;
    u.shift     = 7'(sh);
    u.dst       = d;
    u.d_idx     = di;
    u.neg       = 1'b0;
    u.sat_state = 1'b0;
    u.chk_zero  = 1'b0;
    u.ch        = 1'b0;
    u.last      = 1'b0;
    return u;
  endfunction

  // One channel's update, with the pitch sign pattern when ch is 0
  function automatic uinst_t ch_step(logic [PC_W-1:0] step, logic ch);
    uinst_t u;
    logic   pitch;
    pitch = ~ch;
    case (step)
      6'd0:  u = mk(OP_MUL, SRC_DYNP, T_T0, SRC_AREA, T_T0, STATE_FRAC_BITS - 16,
                    DST_TMP, T_QA);
      6'd1:  u = mk(OP_MUL, SRC_TMP, T_QA, SRC_ASLOPE, T_T0, -16, DST_TMP, T_T0);
      6'd2:  u = mk(OP_ADD, SRC_TMP, T_T0, SRC_THR, T_T0, 0, DST_TMP, T_DEN);
      6'd3:  u = mk(OP_MUL, SRC_SPEED, T_T0, SRC_MASS, T_T0, STATE_FRAC_BITS - 12,
                    DST_TMP, T_NUM);
      6'd4:  begin
        u = mk(OP_DIV, SRC_TMP, T_NUM, SRC_TMP, T_DEN, STATE_FRAC_BITS, DST_TMP, T_TI);
        u.chk_zero = 1'b1;
      end
      6'd5:  u = mk(OP_MUL, SRC_TMP, T_QA, SRC_COEF, T_T0, -16, DST_TMP, T_T0);
      6'd6:  u = mk(OP_DIV, SRC_TMP, T_T0, SRC_MASS, T_T0, 4, DST_TMP, T_FORCE);
      6'd7:  u = mk(OP_MUL, SRC_CMD, T_T0, SRC_GRAV, T_T0, STATE_FRAC_BITS - 32,
                    DST_TMP, T_ACC);
      6'd8:  begin
        if (pitch) begin
          u = mk(OP_SUB, SRC_TMP, T_FORCE, SRC_TMP, T_ACC, 0, DST_TMP, T_ERR);
        end else begin
          u = mk(OP_SUB, SRC_TMP, T_ACC, SRC_TMP, T_FORCE, 0, DST_TMP, T_ERR);
        end
      end
      6'd9:  u = mk(OP_MUL, SRC_GACP, T_T0, SRC_TMP, T_TI, -16, DST_TMP, T_T0);
      6'd10: u = mk(OP_MUL, SRC_TMP, T_T0, SRC_TR, T_T0, -16, DST_TMP, T_T0);
      6'd11: u = mk(OP_DIV, SRC_TMP, T_T0, SRC_SPEED, T_T0, 8, DST_TMP, T_GR);
      6'd12: u = mk(OP_DIV, SRC_TMP, T_GR, SRC_TA, T_T0, 16, DST_TMP, T_GI);
      6'd13: begin
        u = mk(OP_MUL, SRC_TMP, T_GI, SRC_TMP, T_ERR, -STATE_FRAC_BITS, DST_NEW, ST_INTD);
        u.sat_state = 1'b1;
      end
      6'd14: u = mk(OP_ADD, SRC_NEW, ST_INTD, SRC_OLD, ST_INTD, 0, DST_TMP, T_T0);
      6'd15: u = mk(OP_MUL, SRC_TMP, T_T0, SRC_DT, T_T0, -25, DST_TMP, T_T0);
      6'd16: begin
        u = mk(OP_ADD, SRC_OLD, ST_INT, SRC_TMP, T_T0, 0, DST_NEW, ST_INT);
        u.sat_state = 1'b1;
      end
      6'd17: u = mk(OP_MUL, SRC_TMP, T_ERR, SRC_TMP, T_GR, -STATE_FRAC_BITS, DST_TMP, T_T0);
      6'd18: begin
        u = mk(OP_ADD, SRC_TMP, T_T0, SRC_NEW, ST_INT, 0, DST_TMP, T_RC);
        u.neg = pitch;
      end
      6'd19: u = mk(OP_SUB, SRC_TMP, T_RC, SRC_OLD, ST_RATE, 0, DST_TMP, T_T0);
      6'd20: begin
        u = mk(OP_DIV, SRC_TMP, T_T0, SRC_TR, T_T0, 16, DST_NEW, ST_RATED);
        u.sat_state = 1'b1;
      end
      6'd21: u = mk(OP_ADD, SRC_NEW, ST_RATED, SRC_OLD, ST_RATED, 0, DST_TMP, T_T0);
      6'd22: u = mk(OP_MUL, SRC_TMP, T_T0, SRC_DT, T_T0, -25, DST_TMP, T_T0);
      6'd23: begin
        u = mk(OP_ADD, SRC_OLD, ST_RATE, SRC_TMP, T_T0, 0, DST_NEW, ST_RATE);
        u.sat_state = 1'b1;
      end
      6'd24: u = mk(OP_DIV, SRC_OLD, ST_ANG, SRC_TMP, T_TI, STATE_FRAC_BITS, DST_TMP, T_T1);
      6'd25: begin
        if (pitch) begin
          u = mk(OP_SUB, SRC_NEW, ST_RATE, SRC_TMP, T_T1, 0, DST_NEW, ST_ANGD);
        end else begin
          u = mk(OP_ADD, SRC_NEW, ST_RATE, SRC_TMP, T_T1, 0, DST_NEW, ST_ANGD);
          u.neg = 1'b1;
        end
        u.sat_state = 1'b1;
      end
      6'd26: u = mk(OP_ADD, SRC_NEW, ST_ANGD, SRC_OLD, ST_ANGD, 0, DST_TMP, T_T0);
      6'd27: u = mk(OP_MUL, SRC_TMP, T_T0, SRC_DT, T_T0, -25, DST_TMP, T_T0);
      6'd28: begin
        u = mk(OP_ADD, SRC_OLD, ST_ANG, SRC_TMP, T_T0, 0, DST_NEW, ST_ANG);
        u.sat_state = 1'b1;
      end
      default: u = mk(OP_ADD, SRC_ONE, T_T0, SRC_ONE, T_T0, 0, DST_TMP, T_T1);
    endcase
    u.ch = ch;
    return u;
  endfunction

  // Commit, then the output conversions
  function automatic uinst_t tail_step(logic [PC_W-1:0] step);
    uinst_t u;
    case (step)
      6'd0: u = mk(OP_COMMIT, SRC_ONE, T_T0, SRC_ONE, T_T0, 0, DST_TMP, T_T1);
      6'd1: u = mk(OP_MUL, SRC_OLD, ST_ANG, SRC_RAD, T_T0, 16 - STATE_FRAC_BITS - 30,
                   DST_ALPHA, T_T0);
      6'd2: begin
        u = mk(OP_MUL, SRC_OLD, ST_ANG, SRC_RAD, T_T0, 16 - STATE_FRAC_BITS - 30,
               DST_BETA, T_T0);
        u.ch = 1'b1;
      end
      default: begin
        u = mk(OP_MUL, SRC_TMP, T_TI, SRC_ONE, T_T0, 16 - STATE_FRAC_BITS, DST_LAG, T_T0);
        u.last = 1'b1;
      end
    endcase
    return u;
  endfunction

  function automatic uinst_t uc_rom(logic [PC_W-1:0] pc);
    uinst_t u;
    if (pc < PC_W'(CH_LEN)) begin
      u = ch_step(pc, 1'b0);
    end else if (pc < PC_W'(2 * CH_LEN)) begin
      u = ch_step(pc - PC_W'(CH_LEN), 1'b1);
    end else begin
      u = tail_step(pc - PC_W'(2 * CH_LEN));
    end
    return u;
  endfunction

endpackage

/* rtl/core/acceleration_autopilot_pi_rate.sv */
// Two-channel acceleration autopilot with P-I rate loop, built on a microcoded serial datapath.
//
// Usage: one input transaction is one control tick carrying the air data, mass,
// force coefficients and the two acceleration commands. Each tick yields one
// output transaction with the limited angle of attack and sideslip in degrees,
// the pitch incidence lag time and a fault flag. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle. The block does not enforce this.
// Structure: a microcode program of 62 steps runs over a bit-serial multiplier
// and a bit-serial restoring divider, each step fed from a 64-entry working
// store with registered reads. The input is taken again the cycle after the
// result moves into the output register. A new tick is accepted while an earlier
// result still waits in the output register. If the receiver stalls, the finished
// result waits in the sequencer until the output register frees up, and no new
// tick is taken meanwhile. Reset clears the sequencer, the output valid flag and
// all loop states (state entries read as zero until first written) and loads the
// register defaults. On a fault the states are held and the angles come from the
// held states.
module acceleration_autopilot_pi_rate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [19:0]        dyn_pressure_i,
  input  logic [19:0]        airspeed_i,
  input  logic signed [23:0] side_coeff_i,
  input  logic signed [23:0] normal_coeff_i,
  input  logic signed [23:0] normal_slope_i,
  input  logic signed [23:0] side_slope_i,
  input  logic [19:0]        thrust_force_i,
  input  logic [19:0]        vehicle_mass_i,
  input  logic signed [23:0] normal_accel_cmd_i,
  input  logic signed [23:0] lateral_accel_cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] alpha_deg_o,
  output logic signed [24:0] beta_deg_o,
  output logic [23:0]        pitch_lag_time_o,
  output logic               fault_o
);
  import aapr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_LDB  = 7'b0001000,
    S_EXEC = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  localparam logic signed [VAL_W:0] SUM_MAX = {2'b00, VAL_MAX[VAL_W-2:0]};

  // Control registers
  state_e           state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bank_q, bank_d;
  logic             fault_q, fault_d;
  logic             out_valid_q, out_valid_d;

  // Configuration registers
  logic [23:0] gravity_q, ref_area_q, max_inc_q, gain_ratio_q;
  logic [23:0] rate_tc_q, loop_gain_q, time_step_q;

  // Captured tick
  logic [19:0]        dynp_q, speed_q, thrust_q, mass_q;
  logic signed [23:0] scoef_q, ncoef_q, nslope_q, sslope_q, ncmd_q, lcmd_q;

  // Working store with valid bits
  logic [VAL_W-1:0]     mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [VAL_W-1:0]     rd_mem_q;
  logic                 rd_vld_q;
  logic [ADDR_W-1:0]    ra, wa;
  logic                 mem_we;
  logic [VAL_W-1:0]     rd_val;

  // Datapath registers
  logic signed [VAL_W-1:0] opa_q, opb_q;
  logic [2*VAL_W-1:0]      prod_q;
  logic [VAL_W-1:0]        rem_q;
  logic signed [24:0]      alpha_res_q, beta_res_q, alpha_q, beta_q;
  logic [23:0]             lag_res_q, lag_q;
  logic                    fault_out_q;

  uinst_t                  ui;
  logic                    accept, load_out, exec_last;
  logic signed [VAL_W-1:0] a_val, b_val, res;
  logic [VAL_W-1:0]        ma, mb, mbv;
  logic [6:0]              lsh, rsh;

  assign ui     = uc_rom(pc_q);
  assign accept = in_valid_i && !in_stall_o;
  assign rd_val = rd_vld_q ? rd_mem_q : '0;

  function automatic logic [ADDR_W-1:0] mem_addr(src_e s, logic [3:0] idx, logic ch,
                                                 logic bank);
    logic [ADDR_W-1:0] a;
    case (s)
      SRC_OLD: a = {1'b1, bank, ch, idx[2:0]};
      SRC_NEW: a = {1'b1, ~bank, ch, idx[2:0]};
      default: a = {1'b0, ch, idx};
    endcase
    return a;
  endfunction

  function automatic logic signed [VAL_W-1:0] src_val(src_e s, logic ch);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] sl;
    sl = ch ? VAL_W'(sslope_q) : VAL_W'(nslope_q);
    case (s)
      SRC_TMP, SRC_OLD, SRC_NEW: v = rd_val;
      SRC_DYNP:   v = VAL_W'(dynp_q);
      SRC_AREA:   v = VAL_W'(ref_area_q);
      SRC_THR:    v = VAL_W'(thrust_q) << STATE_FRAC_BITS;
      SRC_SPEED:  v = VAL_W'(speed_q);
      SRC_MASS:   v = VAL_W'(mass_q);
      SRC_ASLOPE: v = sl[VAL_W-1] ? -sl : sl;
      SRC_COEF:   v = ch ? VAL_W'(scoef_q) : VAL_W'(ncoef_q);
      SRC_CMD:    v = ch ? VAL_W'(lcmd_q) : VAL_W'(ncmd_q);
      SRC_GRAV:   v = VAL_W'(gravity_q);
      SRC_GACP:   v = VAL_W'(loop_gain_q);
      SRC_TR:     v = VAL_W'(rate_tc_q);
      SRC_TA:     v = VAL_W'(gain_ratio_q);
      SRC_DT:     v = VAL_W'(time_step_q);
      SRC_RAD:    v = RAD2DEG;
      SRC_ONE:    v = VAL_W'(1);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Operand selection and magnitudes
  always_comb begin
    a_val = src_val(ui.a_src, ui.ch);
    b_val = src_val(ui.b_src, ui.ch);
    ma    = opa_q[VAL_W-1] ? -opa_q : opa_q;
    mb    = opb_q[VAL_W-1] ? -opb_q : opb_q;
    mbv   = b_val[VAL_W-1] ? -b_val : b_val;
    lsh   = (ui.shift > 7'sd0) ? 7'(ui.shift) : 7'd0;
    rsh   = (ui.shift < 7'sd0) ? 7'(-ui.shift) : 7'd0;
    ra    = (state_q == S_RDA) ? mem_addr(ui.a_src, ui.a_idx, ui.ch, bank_q)
                               : mem_addr(ui.b_src, ui.b_idx, ui.ch, bank_q);
    wa    = (ui.dst == DST_NEW) ? {1'b1, ~bank_q, ui.ch, ui.d_idx[2:0]}
                                : {1'b0, ui.ch, ui.d_idx};
  end

  // Result formation: scale, saturate, sign
  logic [2*VAL_W-1:0]      sh_p;
  logic                    ovf, sgn;
  logic [VAL_W-1:0]        mag;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] pre;

  always_comb begin
    sgn  = opa_q[VAL_W-1] ^ opb_q[VAL_W-1];
    sh_p = (ui.op == OP_MUL) ? ((prod_q << lsh) >> rsh) : prod_q;
    ovf  = (|sh_p[2*VAL_W-1:VAL_W-1]) ||
           ((ui.op == OP_MUL) && (lsh != 7'd0) && (|prod_q[2*VAL_W-1:VAL_W-1]));
    mag  = ovf ? VAL_MAX : {1'b0, sh_p[VAL_W-2:0]};
    sum  = (ui.op == OP_SUB) ? ({opa_q[VAL_W-1], opa_q} - {opb_q[VAL_W-1], opb_q})
                             : ({opa_q[VAL_W-1], opa_q} + {opb_q[VAL_W-1], opb_q});
    case (ui.op)
      OP_MUL: pre = sgn ? -$signed(mag) : $signed(mag);
      OP_DIV: pre = (opb_q == '0) ? '0 : (sgn ? -$signed(mag) : $signed(mag));
      default: begin
        if (sum > SUM_MAX) begin
          pre = $signed(VAL_MAX);
        end else if (sum < -SUM_MAX) begin
          pre = -$signed(VAL_MAX);
        end else begin
          pre = sum[VAL_W-1:0];
        end
        if (ui.neg) pre = -pre;
      end
    endcase
    res = pre;
    if (ui.sat_state) begin
      if (pre > $signed(STATE_MAX)) begin
        res = $signed(STATE_MAX);
      end else if (pre < -$signed(STATE_MAX)) begin
        res = -$signed(STATE_MAX);
      end
    end
  end

  assign exec_last = ((ui.op == OP_MUL) && (cnt_q == CNT_W'(MUL_STEPS - 1))) ||
                     ((ui.op == OP_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1)));

  // Sequencer
  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    bank_d   = bank_q;
    fault_d  = fault_q;
    mem_we   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RDA;
          pc_d    = '0;
          fault_d = (airspeed_i == '0) || (vehicle_mass_i == '0) ||
                    (gain_ratio_q == '0) || (rate_tc_q == '0);
        end
      end
      S_RDA: begin
        if (ui.op == OP_COMMIT) begin
          bank_d = bank_q ^ ~fault_q;
          pc_d   = pc_q + PC_W'(1);
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: state_d = S_LDB;
      S_LDB: begin
        cnt_d   = '0;
        state_d = ((ui.op == OP_MUL) || (ui.op == OP_DIV)) ? S_EXEC : S_FIN;
      end
      S_EXEC: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (exec_last) state_d = S_FIN;
      end
      S_FIN: begin
        mem_we = (ui.dst == DST_TMP) || (ui.dst == DST_NEW);
        if (ui.chk_zero && (res == '0)) fault_d = 1'b1;
        pc_d    = pc_q + PC_W'(1);
        state_d = ui.last ? S_DONE : S_RDA;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      bank_q      <= bank_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q    <= 24'd642908;
      ref_area_q   <= 24'd655;
      max_inc_q    <= 24'd1310720;
      gain_ratio_q <= 24'd131072;
      rate_tc_q    <= 24'd6554;
      loop_gain_q  <= 24'd655360;
      time_step_q  <= 24'd16777;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAVITY:   gravity_q    <= cfg_data_i;
        CFG_REF_AREA:  ref_area_q   <= cfg_data_i;
        CFG_MAX_INC:   max_inc_q    <= cfg_data_i;
        CFG_GAIN_RAT:  gain_ratio_q <= cfg_data_i;
        CFG_RATE_TC:   rate_tc_q    <= cfg_data_i;
        CFG_LOOP_GAIN: loop_gain_q  <= cfg_data_i;
        CFG_TIME_STEP: time_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Working store: valid bits reset, data does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[wa] <= 1'b1;
      rd_vld_q <= vld_q[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa] <= res;
    rd_mem_q <= mem[ra];
  end

  // Tick capture, serial units and result staging
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dynp_q   <= dyn_pressure_i;
      speed_q  <= airspeed_i;
      scoef_q  <= side_coeff_i;
      ncoef_q  <= normal_coeff_i;
      nslope_q <= normal_slope_i;
      sslope_q <= side_slope_i;
      thrust_q <= thrust_force_i;
      mass_q   <= vehicle_mass_i;
      ncmd_q   <= normal_accel_cmd_i;
      lcmd_q   <= lateral_accel_cmd_i;
    end
    case (state_q)
      S_RDB: opa_q <= a_val;
      S_LDB: begin
        opb_q <= b_val;
        rem_q <= '0;
        if (ui.op == OP_MUL) begin
          prod_q <= {{VAL_W{1'b0}}, mbv};
        end else begin
          prod_q <= {{VAL_W{1'b0}}, ma} << lsh;
        end
      end
      S_EXEC: begin
        if (ui.op == OP_MUL) begin
          // shift-add, one multiplier bit per cycle
          prod_q <= {({1'b0, prod_q[2*VAL_W-1:VAL_W]} +
                      (prod_q[0] ? {1'b0, ma} : {(VAL_W+1){1'b0}})),
                     prod_q[VAL_W-1:1]};
        end else begin
          // restoring division, one quotient bit per cycle
          if ({rem_q[VAL_W-2:0], prod_q[2*VAL_W-1]} >= mb) begin
            rem_q  <= {rem_q[VAL_W-2:0], prod_q[2*VAL_W-1]} - mb;
            prod_q <= {prod_q[2*VAL_W-2:0], 1'b1};
          end else begin
            rem_q  <= {rem_q[VAL_W-2:0], prod_q[2*VAL_W-1]};
            prod_q <= {prod_q[2*VAL_W-2:0], 1'b0};
          end
        end
      end
      S_FIN: begin
        case (ui.dst)
          DST_ALPHA, DST_BETA: begin
            if (res > $signed(VAL_W'(max_inc_q))) begin
              if (ui.dst == DST_ALPHA) alpha_res_q <= 25'(max_inc_q);
              else beta_res_q <= 25'(max_inc_q);
            end else if (res < -$signed(VAL_W'(max_inc_q))) begin
              if (ui.dst == DST_ALPHA) alpha_res_q <= -$signed(25'(max_inc_q));
              else beta_res_q <= -$signed(25'(max_inc_q));
            end else begin
              if (ui.dst == DST_ALPHA) alpha_res_q <= res[24:0];
              else beta_res_q <= res[24:0];
            end
          end
          DST_LAG: begin
            if (res[VAL_W-1]) lag_res_q <= '0;
            else if (|res[VAL_W-2:24]) lag_res_q <= '1;
            else lag_res_q <= res[23:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (load_out) begin
      alpha_q     <= alpha_res_q;
      beta_q      <= beta_res_q;
      lag_q       <= lag_res_q;
      fault_out_q <= fault_q;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign alpha_deg_o      = alpha_q;
  assign beta_deg_o       = beta_q;
  assign pitch_lag_time_o = lag_q;
  assign fault_o          = fault_out_q;

`ifndef ASSERT_OFF
  // An accepted tick starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RDA) && (pc_q == '0))
    else $error("tick accepted without starting the program");

  // The state bank only moves on the commit step of a fault-free tick
  a_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bank_q) |-> $past((state_q == S_RDA) && (ui.op == OP_COMMIT) && !fault_q))
    else $error("state bank flipped outside commit");

  // Divider remainder stays below a nonzero divisor
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && (ui.op == OP_DIV) && (opb_q != '0)) |-> (rem_q < mb))
    else $error("divider remainder out of range");

  // A finished result reaches the output register once it is free
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && (state_q == S_IDLE)))
    else $error("finished result not delivered");
`endif

endmodule

/* test/acceleration_autopilot_pi_rate_tb.sv */
// Self-checking testbench for the two-channel acceleration autopilot.
`timescale 1ns / 100ps

module acceleration_autopilot_pi_rate_tb;
  import aapr_pkg::*;

  localparam int FB       = STATE_FRAC_BITS;
  localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int WD_LIMIT = 20000;

  typedef longint vec6_t[6];

  typedef struct {
    logic [19:0]        q, v, thr, m;
    logic signed [23:0] scoef, ncoef, nslope, sslope, ncmd, lcmd;
  } tick_t;

  typedef struct {
    logic [24:0] alpha, beta;
    logic [23:0] lag;
    logic        flt;
  } angles_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  tick_t cur = '{default: '0};
  logic signed [24:0] alpha_o, beta_o;
  logic [23:0] lag_o;
  logic fault_o;

  tick_t   pending_q[$];
  angles_t expected_q[$];
  int      err_cnt = 0;
  int      idle_cycles = 0;
  bit      idle_en = 1'b0;
  int      in_gap = 0, stall_len = 0;

  // Predictor copy of registers and loop states
  longint reg_val[7];
  vec6_t  pitch_st, yaw_st;

  acceleration_autopilot_pi_rate uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .dyn_pressure_i(cur.q), .airspeed_i(cur.v),
    .side_coeff_i(cur.scoef), .normal_coeff_i(cur.ncoef),
    .normal_slope_i(cur.nslope), .side_slope_i(cur.sslope),
    .thrust_force_i(cur.thr), .vehicle_mass_i(cur.m),
    .normal_accel_cmd_i(cur.ncmd), .lateral_accel_cmd_i(cur.lcmd),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .alpha_deg_o(alpha_o), .beta_deg_o(beta_o),
    .pitch_lag_time_o(lag_o), .fault_o(fault_o)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- fixed-point arithmetic ----------------
  function automatic logic [63:0] umag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [63:0] scale_mag(logic [127:0] x, int s);
    if (s < 0) x = x >> (-s);
    if (x > 128'(LMAX)) return 64'(LMAX);
    if (s <= 0) return x[63:0];
    if (s >= 63) return x != 0 ? 64'(LMAX) : 64'd0;
    if (x[63:0] > (64'(LMAX) >> s)) return 64'(LMAX);
    return x[63:0] << s;
  endfunction

  function automatic longint apply_sign(logic [63:0] m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, int fa, longint b, int fb, int fr);
    logic [127:0] p;
    p = 128'(umag(a)) * 128'(umag(b));
    return apply_sign(scale_mag(p, fr - fa - fb), (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, int fa, longint b, int fb, int fr);
    logic [127:0] n;
    int s;
    s = fr - fa + fb;
    if (b == 0) return 0;
    n = 128'(umag(a));
    n = s >= 0 ? (n << s) : (n >> (-s));
    return apply_sign(scale_mag(n / 128'(umag(b)), 0), (a < 0) != (b < 0));
  endfunction

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > LMAX - b) return LMAX;
    if (b < 0 && a < -LMAX - b) return -LMAX;
    return a + b;
  endfunction

  function automatic longint clamp_state(longint v);
    longint hi;
    hi = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
    return v > hi ? hi : (v < -hi ? -hi : v);
  endfunction

  function automatic longint trapezoid(longint x, longint dn, longint d0);
    return clamp_state(sat_add(x, fx_mul(sat_add(dn, d0), FB, reg_val[CFG_TIME_STEP],
                                         25, FB)));
  endfunction

  // One channel's loop update; pitch selects the pitch sign pattern
  function automatic bit update_channel(input vec6_t st, output vec6_t nw, input longint qa,
                                        input longint v, input longint m, input longint thr,
                                        input longint cmd, input longint coef,
                                        input longint slope, input bit pitch,
                                        output longint ti);
    longint den, num, force_v, acc, err, gr, gi, rc, rate;
    nw = '{default: 0};
    den = sat_add(fx_mul(qa, FB, slope < 0 ? -slope : slope, 16, FB), thr);
    num = fx_mul(v, 8, m, 4, FB);
    ti = den != 0 ? fx_div(num, FB, den, FB, FB) : 0;
    if (den == 0 || v == 0 || m == 0 || reg_val[CFG_GAIN_RAT] == 0 ||
        reg_val[CFG_RATE_TC] == 0 || ti == 0) return 1'b0;
    force_v = fx_div(fx_mul(qa, FB, coef, 16, FB), FB, m, 4, FB);
    acc = fx_mul(cmd, 16, reg_val[CFG_GRAVITY], 16, FB);
    err = pitch ? sat_add(-acc, force_v) : sat_add(acc, -force_v);
    gr = fx_div(fx_mul(fx_mul(reg_val[CFG_LOOP_GAIN], 16, ti, FB, FB), FB,
                       reg_val[CFG_RATE_TC], 16, FB), FB, v, 8, FB);
    gi = fx_div(gr, FB, reg_val[CFG_GAIN_RAT], 16, FB);
    nw[1] = clamp_state(fx_mul(gi, FB, err, FB, FB));
    nw[0] = trapezoid(st[0], nw[1], st[1]);
    rc = sat_add(fx_mul(err, FB, gr, FB, FB), nw[0]);
    if (pitch) rc = -rc;
    nw[3] = clamp_state(fx_div(sat_add(rc, -st[2]), FB, reg_val[CFG_RATE_TC], 16, FB));
    nw[2] = trapezoid(st[2], nw[3], st[3]);
    rate = pitch ? nw[2] : -nw[2];
    nw[5] = clamp_state(sat_add(rate, -fx_div(st[4], FB, ti, FB, FB)));
    nw[4] = trapezoid(st[4], nw[5], st[5]);
    return 1'b1;
  endfunction

  function automatic logic [24:0] limited_deg(longint ang);
    longint d, lim;
    d = fx_mul(ang, FB, longint'(RAD2DEG), 30, 16);
    lim = reg_val[CFG_MAX_INC];
    d = d > lim ? lim : (d < -lim ? -lim : d);
    return d[24:0];
  endfunction

  // Advance the loop by one tick and return the expected outputs
  function automatic angles_t autopilot_tick(tick_t t);
    longint qa, thr, tip, tiy, lag;
    vec6_t pn, yn;
    bit okp, oky;
    angles_t r;
    qa = fx_mul(longint'(t.q), 0, reg_val[CFG_REF_AREA], 16, FB);
    thr = fx_mul(longint'(t.thr), 0, 1, 0, FB);
    okp = update_channel(pitch_st, pn, qa, longint'(t.v), longint'(t.m), thr,
                         longint'(t.ncmd), longint'(t.ncoef), longint'(t.nslope),
                         1'b1, tip);
    oky = update_channel(yaw_st, yn, qa, longint'(t.v), longint'(t.m), thr,
                         longint'(t.lcmd), longint'(t.scoef), longint'(t.sslope),
                         1'b0, tiy);
    if (okp && oky) begin
      pitch_st = pn;
      yaw_st = yn;
    end
    lag = fx_mul(tip, FB, 1, 0, 16);
    if (lag < 0) lag = 0;
    if (lag > 64'hFF_FFFF) lag = 64'hFF_FFFF;
    r.alpha = limited_deg(pitch_st[4]);
    r.beta = limited_deg(yaw_st[4]);
    r.lag = lag[23:0];
    r.flt = !(okp && oky);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic signed [23:0] srand(int mag);
    return 24'($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  // Mostly plausible flight conditions, some raw noise
  function automatic tick_t random_tick();
    tick_t t;
    if ($urandom_range(0, 99) < 15) begin
      t.q = 20'($urandom); t.v = 20'($urandom); t.thr = 20'($urandom);
      t.m = 20'($urandom_range(1, 20'hFFFFF));
      t.scoef = 24'($urandom); t.ncoef = 24'($urandom);
      t.nslope = 24'($urandom); t.sslope = 24'($urandom);
      t.ncmd = 24'($urandom); t.lcmd = 24'($urandom);
    end else begin
      t.q = 20'($urandom_range(0, 400000));
      t.v = 20'($urandom_range(50 * 256, 1500 * 256));
      t.thr = 20'($urandom_range(0, 60000));
      t.m = 20'($urandom_range(16 * 50, 16 * 3000));
      t.scoef = srand(3 << 16); t.ncoef = srand(3 << 16);
      t.nslope = srand(40 << 16); t.sslope = srand(40 << 16);
      t.ncmd = srand(40 << 16); t.lcmd = srand(40 << 16);
    end
    return t;
  endfunction

  function automatic tick_t nominal_tick(int ncmd_g, int lcmd_g);
    tick_t t;
    t.q = 20'd50000; t.v = 20'(600 * 256); t.thr = 20'd5000; t.m = 20'(16 * 500);
    t.scoef = 24'sd13107; t.ncoef = -24'sd13107;
    t.nslope = 24'(20 << 16); t.sslope = -24'(18 << 16);
    t.ncmd = 24'(ncmd_g <<< 16); t.lcmd = 24'(lcmd_g <<< 16);
    return t;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_val[idx] = longint'(val);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // ---------------- driver ----------------
  bit in_taken;
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && !in_taken)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur <= pending_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) && idle_en;
        stall_len <= idle_len();
      end
    end
  end

  // ---------------- monitor, predictor and watchdog ----------------
  always @(posedge clk) begin
    angles_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_q.push_back(autopilot_tick(cur));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 64'd0, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (alpha_o !== want.alpha)
            report_mismatch("alpha_deg", 64'(alpha_o), 64'(want.alpha));
          if (beta_o !== want.beta)
            report_mismatch("beta_deg", 64'(beta_o), 64'(want.beta));
          if (lag_o !== want.lag)
            report_mismatch("pitch_lag_time", 64'(lag_o), 64'(want.lag));
          if (fault_o !== want.flt)
            report_mismatch("fault", 64'(fault_o), 64'(want.flt));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
        $display("acceleration_autopilot_pi_rate verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    tick_t t;
    reg_val = '{642908, 655, 1310720, 131072, 6554, 655360, 16777};
    pitch_st = '{default: 0};
    yaw_st = '{default: 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks at reset settings
    pending_q.push_back(nominal_tick(5, -3));
    t = nominal_tick(0, 0); t.q = '0; t.thr = '0; pending_q.push_back(t);  // zero denominator
    t = nominal_tick(2, 2); t.v = '0; pending_q.push_back(t);              // zero speed
    t = nominal_tick(1, 1); t.m = 20'd1; pending_q.push_back(t);
    t = nominal_tick(1, 1); t.m = 20'hFFFFF; pending_q.push_back(t);
    t = nominal_tick(0, 0); t.nslope = '0; t.sslope = '0; pending_q.push_back(t);
    t.q = 20'hFFFFF; t.v = 20'hFFFFF; t.thr = 20'hFFFFF; t.m = 20'hFFFFF;
    t.scoef = 24'sh7FFFFF; t.ncoef = 24'sh7FFFFF; t.nslope = 24'sh7FFFFF;
    t.sslope = 24'sh7FFFFF; t.ncmd = 24'sh7FFFFF; t.lcmd = 24'sh7FFFFF;
    pending_q.push_back(t);
    t.scoef = -24'sh800000; t.ncoef = -24'sh800000; t.nslope = -24'sh800000;
    t.sslope = -24'sh800000; t.ncmd = -24'sh800000; t.lcmd = -24'sh800000;
    pending_q.push_back(t);
    t = nominal_tick(0, 0); t.q = '0; pending_q.push_back(t);              // thrust only
    t = nominal_tick(0, 0); t.v = 20'd1; t.m = 20'd1; t.thr = 20'hFFFFF;
    pending_q.push_back(t);                                               // lag truncates to 0
    // Hard commands held to drive the angles into the limit
    for (int i = 0; i < 12; i++) pending_q.push_back(nominal_tick(120, -120));
    drain();

    // Register settings: random, maxima, minima, random, then random and the reset defaults
    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 7; r++) begin
        case (ph)
          1: write_reg(3'(r), r == CFG_MAX_INC ? 24'd11796480 : 24'hFFFFFF);
          2: write_reg(3'(r), (r == CFG_GRAVITY || r == CFG_MAX_INC ||
                               r == CFG_LOOP_GAIN) ? 24'd0 : 24'd1);
          default: write_reg(3'(r), r == CFG_MAX_INC ? 24'($urandom_range(0, 11796480))
                                                    : 24'($urandom_range(1, 24'hFFFFFF)));
        endcase
      end
      if (ph == 4) begin
        write_reg(CFG_GRAVITY, 24'd642908); write_reg(CFG_REF_AREA, 24'd655);
        write_reg(CFG_MAX_INC, 24'd1310720); write_reg(CFG_GAIN_RAT, 24'd131072);
        write_reg(CFG_RATE_TC, 24'd6554); write_reg(CFG_LOOP_GAIN, 24'd655360);
        write_reg(CFG_TIME_STEP, 24'd16777);
      end
      idle_en = $urandom_range(0, 3) != 0;
      for (int i = 0; i < (ph == 4 ? 350 : 120); i++) pending_q.push_back(random_tick());
      drain();
    end

    if (err_cnt == 0) begin
      $display("acceleration_autopilot_pi_rate verification clean");
    end else begin
      $display("acceleration_autopilot_pi_rate verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/aapr_pkg.sv
rtl/core/acceleration_autopilot_pi_rate.sv
test/acceleration_autopilot_pi_rate_tb.sv
